/* rtl/ccc_pkg.sv */
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, codes and date helpers for the calendar clock counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam logic [2:0] REQ_TICK      = 3'd0;
  localparam logic [2:0] REQ_LOAD_TIME = 3'd1;
  localparam logic [2:0] REQ_LOAD_DATE = 3'd2;
  localparam logic [2:0] REQ_STEP_DATE = 3'd3;
  localparam logic [2:0] REQ_SET_MODE  = 3'd4;

  localparam logic [1:0] MODE_UP   = 2'd0;
  localparam logic [1:0] MODE_HOLD = 2'd1;
  localparam logic [1:0] MODE_DOWN = 2'd2;

  localparam logic [1:0] FIELD_YEAR  = 2'd0;
  localparam logic [1:0] FIELD_MONTH = 2'd1;
  localparam logic [1:0] FIELD_DAY   = 2'd2;

  localparam logic [1:0] CFG_ALARM_EN  = 2'd0;
  localparam logic [1:0] CFG_ALARM_HR  = 2'd1;
  localparam logic [1:0] CFG_ALARM_MIN = 2'd2;
  localparam logic [1:0] CFG_ALARM_SEC = 2'd3;

  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [6:0] YEAR_MAX  = 7'd99;
  localparam logic [3:0] MONTH_MAX = 4'd12;

  typedef struct packed {
    logic [2:0] req_type;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
    logic [6:0] year_in;
    logic [3:0] month_in;
    logic [4:0] day_in;
    logic [1:0] date_field;
    logic       step_down;
    logic [1:0] mode_in;
  } in_item_t;

  typedef struct packed {
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
    logic [6:0] year_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
    logic       alarm_ring;
    logic       countdown_done;
    logic [1:0] mode_out;
  } out_item_t;

  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
  } date_t;

  function automatic logic [4:0] month_len(logic [3:0] m, logic [6:0] y);
    logic [4:0] len;
    case (m)
      4'd2: len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [6:0] year_up(logic [6:0] y);
    return (y >= YEAR_MAX) ? 7'd0 : y + 7'd1;
  endfunction

  function automatic logic [6:0] year_down(logic [6:0] y);
    return (y == 7'd0) ? YEAR_MAX : y - 7'd1;
  endfunction

  function automatic date_t month_up(date_t d);
    date_t r;
    r = d;
    if (d.month >= MONTH_MAX) begin
      r.month = 4'd1;
      r.year  = year_up(d.year);
    end else begin
      r.month = d.month + 4'd1;
    end
    return r;
  endfunction

  function automatic date_t month_down(date_t d);
    date_t r;
    r = d;
    if (d.month <= 4'd1) begin
      r.month = MONTH_MAX;
      r.year  = year_down(d.year);
    end else begin
      r.month = d.month - 4'd1;
    end
    return r;
  endfunction

  function automatic date_t day_up(date_t d);
    date_t r;
    r = d;
    if (d.day >= month_len(d.month, d.year)) begin
      r     = month_up(d);
      r.day = 5'd1;
    end else begin
      r.day = d.day + 5'd1;
    end
    return r;
  endfunction

  function automatic date_t day_down(date_t d);
    date_t r;
    r = d;
    if (d.day <= 5'd1) begin
      r     = month_down(d);
      r.day = month_len(r.month, r.year);
    end else begin
      r.day = d.day - 5'd1;
    end
    return r;
  endfunction

  function automatic date_t clamp_day(date_t d);
    date_t      r;
    logic [4:0] last;
    r    = d;
    last = month_len(d.month, d.year);
    if (r.day > last) r.day = last;
    if (r.day == 5'd0) r.day = 5'd1;
    return r;
  endfunction

endpackage

/* rtl/ccc_if.sv */
// ----------------------------------------------------------------------------
// ccc_in_if / ccc_out_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface ccc_in_if;
  logic               valid;
  logic               ready;
  ccc_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface ccc_out_if;
  logic               valid;
  logic               ready;
  ccc_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

/* rtl/ccc_in_stage.sv */
// ----------------------------------------------------------------------------
// ccc_in_stage
// Input register: captures one request beat, frees up when it moves on.
// ----------------------------------------------------------------------------
module ccc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  ccc_in_if.sink            in_ch,
  input  logic              load_ok,
  output logic              item_valid,
  output ccc_pkg::in_item_t item
);
  import ccc_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ch.ready = !valid_r || load_ok;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid_r <= 1'b1;
    end else if (load_ok) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.item;
    end
  end

endmodule

/* rtl/ccc_core.sv */
// ----------------------------------------------------------------------------
// ccc_core
// Time, date, mode and alarm registers with the single-pass update logic.
// ----------------------------------------------------------------------------
module ccc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ccc_pkg::in_item_t  item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [5:0]         cfg_wdata,
  output ccc_pkg::out_item_t result
);
  import ccc_pkg::*;

  logic [4:0] hour_r, hour_nxt;
  logic [5:0] min_r, min_nxt;
  logic [5:0] sec_r, sec_nxt;
  date_t      date_r, date_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       ring, done;

  logic       alarm_en_r;
  logic [4:0] alarm_hr_r;
  logic [5:0] alarm_min_r;
  logic [5:0] alarm_sec_r;

  date_t      load_date;

  always_comb begin
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    date_nxt  = date_r;
    mode_nxt  = mode_r;
    ring      = 1'b0;
    done      = 1'b0;
    load_date.year  = (item.year_in > YEAR_MAX) ? YEAR_MAX : item.year_in;
    load_date.month = (item.month_in == 4'd0) ? 4'd1 :
                      ((item.month_in > MONTH_MAX) ? MONTH_MAX : item.month_in);
    load_date.day   = item.day_in;
    case (item.req_type)
      REQ_TICK: begin
        case (mode_r)
          MODE_UP: begin
            if (sec_r >= SEC_MAX) begin
              sec_nxt = 6'd0;
              if (min_r >= MIN_MAX) begin
                min_nxt = 6'd0;
                if (hour_r >= HOUR_MAX) begin
                  hour_nxt = 5'd0;
                  date_nxt = day_up(date_r);
                end else begin
                  hour_nxt = hour_r + 5'd1;
                end
              end else begin
                min_nxt = min_r + 6'd1;
              end
            end else begin
              sec_nxt = sec_r + 6'd1;
            end
            ring = alarm_en_r && (hour_nxt == alarm_hr_r) && (min_nxt == alarm_min_r)
                   && (sec_nxt == alarm_sec_r);
          end
          MODE_DOWN: begin
            // borrow through the time; an all-zero time stays put
            if ((hour_r != 5'd0) || (min_r != 6'd0) || (sec_r != 6'd0)) begin
              if (sec_r == 6'd0) begin
                sec_nxt = SEC_MAX;
                if (min_r == 6'd0) begin
                  min_nxt  = MIN_MAX;
                  hour_nxt = hour_r - 5'd1;
                end else begin
                  min_nxt = min_r - 6'd1;
                end
              end else begin
                sec_nxt = sec_r - 6'd1;
              end
            end
            if ((hour_nxt == 5'd0) && (min_nxt == 6'd0) && (sec_nxt == 6'd0)) begin
              done     = 1'b1;
              mode_nxt = MODE_HOLD;
            end
          end
          default: ;
        endcase
      end
      REQ_LOAD_TIME: begin
        hour_nxt = (item.hour_in > HOUR_MAX) ? HOUR_MAX : item.hour_in;
        min_nxt  = (item.minute_in > MIN_MAX) ? MIN_MAX : item.minute_in;
        sec_nxt  = (item.second_in > SEC_MAX) ? SEC_MAX : item.second_in;
      end
      REQ_LOAD_DATE: begin
        date_nxt = clamp_day(load_date);
      end
      REQ_STEP_DATE: begin
        case (item.date_field)
          FIELD_YEAR: begin
            date_nxt      = date_r;
            date_nxt.year = item.step_down ? year_down(date_r.year) : year_up(date_r.year);
            date_nxt      = clamp_day(date_nxt);
          end
          FIELD_MONTH: begin
            date_nxt = clamp_day(item.step_down ? month_down(date_r) : month_up(date_r));
          end
          FIELD_DAY: begin
            date_nxt = item.step_down ? day_down(date_r) : day_up(date_r);
          end
          default: ;
        endcase
      end
      REQ_SET_MODE: begin
        if ((item.mode_in == MODE_UP) || (item.mode_in == MODE_HOLD) ||
            (item.mode_in == MODE_DOWN)) begin
          mode_nxt = item.mode_in;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.hour_out       = hour_nxt;
    result.minute_out     = min_nxt;
    result.second_out     = sec_nxt;
    result.year_out       = date_nxt.year;
    result.month_out      = date_nxt.month;
    result.day_out        = date_nxt.day;
    result.alarm_ring     = ring;
    result.countdown_done = done;
    result.mode_out       = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hour_r <= 5'd0;
      min_r  <= 6'd0;
      sec_r  <= 6'd0;
      date_r <= '{year: 7'd0, month: 4'd1, day: 5'd1};
      mode_r <= MODE_UP;
    end else if (fire) begin
      hour_r <= hour_nxt;
      min_r  <= min_nxt;
      sec_r  <= sec_nxt;
      date_r <= date_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_en_r  <= 1'b0;
      alarm_hr_r  <= 5'd0;
      alarm_min_r <= 6'd0;
      alarm_sec_r <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ALARM_EN:  alarm_en_r  <= cfg_wdata[0];
        CFG_ALARM_HR:  alarm_hr_r  <= cfg_wdata[4:0];
        CFG_ALARM_MIN: alarm_min_r <= cfg_wdata;
        CFG_ALARM_SEC: alarm_sec_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ccc_out_stage.sv */
// ----------------------------------------------------------------------------
// ccc_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module ccc_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ccc_pkg::out_item_t result,
  output logic               load_ok,
  ccc_out_if.source          out_ch
);
  import ccc_pkg::*;

  logic      valid_r;
  out_item_t item_r;

  assign load_ok      = !valid_r || out_ch.ready;
  assign out_ch.valid = valid_r;
  assign out_ch.item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item_r <= result;
    end
  end

endmodule

/* rtl/calendar_clock_counter_top.sv */
// A request beat passes through the input register, then the result register,
// before it shows up as a result beat. The stages take one beat per cycle while
// the sink keeps ready high, set by the single-pass update of the time/date registers.
// Reset (rst_n low, synchronous): 00:00:00 on year 0, month 1, day 1, count-up
// mode, alarm disabled and zeroed, both channel stages empty.
// ----------------------------------------------------------------------------
// calendar_clock_counter_top
// Real-time clock and calendar with daily alarm and count-down timer.
// ----------------------------------------------------------------------------
module calendar_clock_counter_top (
  input  logic       clk,
  input  logic       rst_n,
  ccc_in_if.sink     in_ch,
  ccc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_idx,
  input  logic [5:0] cfg_wdata
);
  import ccc_pkg::*;

  logic      item_valid;
  in_item_t  item;
  out_item_t result;
  logic      load_ok;
  logic      fire;

  // advance a beat from the input register into the result register
  assign fire = item_valid && load_ok;

  ccc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .load_ok    (load_ok),
    .item_valid (item_valid),
    .item       (item)
  );

  ccc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  ccc_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .result  (result),
    .load_ok (load_ok),
    .out_ch  (out_ch)
  );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calendar clock counter: a queue-fed driver and
// a monitor that predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module tb;
  import ccc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 215;
  localparam int NUM_PHASES  = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [5:0] cfg_wdata;

  ccc_in_if  in_bus ();
  ccc_out_if out_bus ();

  calendar_clock_counter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // predicted clock/calendar state and alarm register copy
  logic [5:0] now_sec, now_min;
  logic [4:0] now_hr, now_day;
  logic [3:0] now_mon;
  logic [6:0] now_yr;
  logic [1:0] now_mode;
  logic       al_en;
  logic [4:0] al_hr;
  logic [5:0] al_min, al_sec;

  in_item_t  pending_requests[$];
  out_item_t expected_readings[$];

  int send_max_gap, recv_max_gap;
  int send_wait, recv_wait;
  logic in_taken, out_taken;
  int cycles, failures, queued_items;
  int n_requests, n_results, n_rings, n_expiries, n_midnights;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [4:0] last_day_of(logic [3:0] m, logic [6:0] y);
    case (m)
      4'd2: return (y % 4 == 0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  function automatic void roll_month_fwd();
    if (now_mon >= MONTH_MAX) begin
      now_mon = 4'd1;
      now_yr  = (now_yr >= YEAR_MAX) ? 7'd0 : now_yr + 7'd1;
    end else begin
      now_mon = now_mon + 4'd1;
    end
  endfunction

  function automatic void roll_month_back();
    if (now_mon <= 4'd1) begin
      now_mon = MONTH_MAX;
      now_yr  = (now_yr == 7'd0) ? YEAR_MAX : now_yr - 7'd1;
    end else begin
      now_mon = now_mon - 4'd1;
    end
  endfunction

  function automatic void bump_day();
    if (now_day >= last_day_of(now_mon, now_yr)) begin
      now_day = 5'd1;
      roll_month_fwd();
    end else begin
      now_day = now_day + 5'd1;
    end
  endfunction

  function automatic void fit_day();
    logic [4:0] last;
    last = last_day_of(now_mon, now_yr);
    if (now_day > last) now_day = last;
    if (now_day == 5'd0) now_day = 5'd1;
  endfunction

  function automatic out_item_t advance_calendar(in_item_t req);
    out_item_t res;
    logic      ring, done;
    ring = 1'b0;
    done = 1'b0;
    case (req.req_type)
      REQ_TICK: begin
        if (now_mode == MODE_UP) begin
          if (now_sec >= SEC_MAX) begin
            now_sec = 6'd0;
            if (now_min >= MIN_MAX) begin
              now_min = 6'd0;
              if (now_hr >= HOUR_MAX) begin
                now_hr = 5'd0;
                bump_day();
                n_midnights++;
              end else begin
                now_hr = now_hr + 5'd1;
              end
            end else begin
              now_min = now_min + 6'd1;
            end
          end else begin
            now_sec = now_sec + 6'd1;
          end
          ring = al_en && now_hr == al_hr && now_min == al_min && now_sec == al_sec;
        end else if (now_mode == MODE_DOWN) begin
          if (now_hr != 0 || now_min != 0 || now_sec != 0) begin
            if (now_sec == 0) begin
              now_sec = SEC_MAX;
              if (now_min == 0) begin
                now_min = MIN_MAX;
                now_hr  = now_hr - 5'd1;
              end else begin
                now_min = now_min - 6'd1;
              end
            end else begin
              now_sec = now_sec - 6'd1;
            end
          end
          if (now_hr == 0 && now_min == 0 && now_sec == 0) begin
            done     = 1'b1;
            now_mode = MODE_HOLD;
          end
        end
      end
      REQ_LOAD_TIME: begin
        now_hr  = (req.hour_in > HOUR_MAX) ? HOUR_MAX : req.hour_in;
        now_min = (req.minute_in > MIN_MAX) ? MIN_MAX : req.minute_in;
        now_sec = (req.second_in > SEC_MAX) ? SEC_MAX : req.second_in;
      end
      REQ_LOAD_DATE: begin
        now_yr  = (req.year_in > YEAR_MAX) ? YEAR_MAX : req.year_in;
        now_mon = (req.month_in == 0) ? 4'd1 :
                  (req.month_in > MONTH_MAX) ? MONTH_MAX : req.month_in;
        now_day = req.day_in;
        fit_day();
      end
      REQ_STEP_DATE: begin
        case (req.date_field)
          FIELD_YEAR: begin
            if (req.step_down) now_yr = (now_yr == 0) ? YEAR_MAX : now_yr - 7'd1;
            else now_yr = (now_yr >= YEAR_MAX) ? 7'd0 : now_yr + 7'd1;
            fit_day();
          end
          FIELD_MONTH: begin
            if (req.step_down) roll_month_back();
            else roll_month_fwd();
            fit_day();
          end
          FIELD_DAY: begin
            if (!req.step_down) begin
              bump_day();
            end else if (now_day <= 5'd1) begin
              roll_month_back();
              now_day = last_day_of(now_mon, now_yr);
            end else begin
              now_day = now_day - 5'd1;
            end
          end
          default: ;
        endcase
      end
      REQ_SET_MODE: begin
        if (req.mode_in <= MODE_DOWN) now_mode = req.mode_in;
      end
      default: ;
    endcase
    n_rings    += ring;
    n_expiries += done;
    res.hour_out       = now_hr;
    res.minute_out     = now_min;
    res.second_out     = now_sec;
    res.year_out       = now_yr;
    res.month_out      = now_mon;
    res.day_out        = now_day;
    res.alarm_ring     = ring;
    res.countdown_done = done;
    res.mode_out       = now_mode;
    return res;
  endfunction

  // ------------------------------------------------------------------ checking
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_bus.valid && in_bus.ready;
      out_taken <= out_bus.valid && out_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        expected_readings.push_back(advance_calendar(in_bus.item));
        n_requests++;
      end
      if (out_bus.valid && out_bus.ready) begin
        n_results++;
        if (expected_readings.size() == 0) begin
          $error("result beat with no pending request");
          failures++;
        end else begin
          want = expected_readings.pop_front();
          check_field("hour_out", want.hour_out, out_bus.item.hour_out);
          check_field("minute_out", want.minute_out, out_bus.item.minute_out);
          check_field("second_out", want.second_out, out_bus.item.second_out);
          check_field("year_out", want.year_out, out_bus.item.year_out);
          check_field("month_out", want.month_out, out_bus.item.month_out);
          check_field("day_out", want.day_out, out_bus.item.day_out);
          check_field("alarm_ring", want.alarm_ring, out_bus.item.alarm_ring);
          check_field("countdown_done", want.countdown_done,
                      out_bus.item.countdown_done);
          check_field("mode_out", want.mode_out, out_bus.item.mode_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("calendar_clock_counter_top regression: fail");
      $finish;
    end
  end

  // -------------------------------------------------------- driver and sink
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && !in_taken) begin
        // hold the beat until accepted
      end else if (send_wait > 0) begin
        in_bus.valid <= 1'b0;
        send_wait    <= send_wait - 1;
      end else if (pending_requests.size() > 0) begin
        in_bus.item  <= pending_requests.pop_front();
        in_bus.valid <= 1'b1;
        send_wait    <= $urandom_range(0, send_max_gap);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : sink_pace
    int draw;
    if (out_taken) begin
      draw = $urandom_range(0, recv_max_gap);
      if (draw > 0) begin
        out_bus.ready <= 1'b0;
        recv_wait     <= draw - 1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end else if (recv_wait > 0) begin
      out_bus.ready <= 1'b0;
      recv_wait     <= recv_wait - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------ stimulus
  function automatic in_item_t rand_item(logic [2:0] kind);
    logic [63:0] raw;
    in_item_t    it;
    raw         = {$urandom, $urandom};
    it          = raw[$bits(in_item_t)-1:0];
    it.req_type = kind;
    return it;
  endfunction

  function automatic void queue_request(in_item_t it);
    pending_requests.push_back(it);
    queued_items++;
  endfunction

  function automatic void queue_load_time(int h, int m, int s);
    in_item_t it;
    it           = rand_item(REQ_LOAD_TIME);
    it.hour_in   = 5'(h);
    it.minute_in = 6'(m);
    it.second_in = 6'(s);
    queue_request(it);
  endfunction

  function automatic void queue_load_date(int y, int mo, int d);
    in_item_t it;
    it          = rand_item(REQ_LOAD_DATE);
    it.year_in  = 7'(y);
    it.month_in = 4'(mo);
    it.day_in   = 5'(d);
    queue_request(it);
  endfunction

  function automatic void queue_step(logic [1:0] field, logic down);
    in_item_t it;
    it            = rand_item(REQ_STEP_DATE);
    it.date_field = field;
    it.step_down  = down;
    queue_request(it);
  endfunction

  function automatic void queue_mode(logic [1:0] md);
    in_item_t it;
    it         = rand_item(REQ_SET_MODE);
    it.mode_in = md;
    queue_request(it);
  endfunction

  function automatic void queue_ticks(int n);
    for (int i = 0; i < n; i++) queue_request(rand_item(REQ_TICK));
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [5:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_ALARM_EN:  al_en  = data[0];
      CFG_ALARM_HR:  al_hr  = data[4:0];
      CFG_ALARM_MIN: al_min = data;
      CFG_ALARM_SEC: al_sec = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_alarm(input logic [5:0] en, h, m, s);
    cfg_write(CFG_ALARM_EN, en);
    cfg_write(CFG_ALARM_HR, h);
    cfg_write(CFG_ALARM_MIN, m);
    cfg_write(CFG_ALARM_SEC, s);
  endtask

  task automatic wait_idle();
    while (pending_requests.size() != 0 || in_bus.valid || expected_readings.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int pick, k, n;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_ALARM_EN;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.item   = '0;
    out_bus.ready = 1'b0;
    send_wait     = 0;
    recv_wait     = 0;
    send_max_gap  = 17;
    recv_max_gap  = 17;
    {now_sec, now_min, now_hr, now_yr} = '0;
    now_day  = 5'd1;
    now_mon  = 4'd1;
    now_mode = MODE_UP;
    {al_en, al_hr, al_min, al_sec} = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: alarm right after reset, saturating loads, all wrap cases
    write_alarm(6'd1, 6'd0, 6'd0, 6'd1);
    queue_ticks(1);
    queue_load_time(31, 63, 63);
    queue_load_date(127, 15, 31);
    queue_ticks(1);
    queue_load_date(0, 0, 0);
    queue_step(FIELD_DAY, 1'b1);
    queue_step(FIELD_MONTH, 1'b0);
    queue_step(FIELD_MONTH, 1'b1);
    queue_step(FIELD_YEAR, 1'b0);
    queue_step(FIELD_YEAR, 1'b1);
    queue_load_date(0, 2, 31);
    queue_step(FIELD_YEAR, 1'b0);
    queue_step(FIELD_DAY, 1'b0);
    queue_step(FIELD_DAY, 1'b1);
    queue_load_date(4, 1, 31);
    queue_step(FIELD_MONTH, 1'b0);
    queue_step(2'd3, 1'b0);
    queue_mode(2'd3);
    queue_mode(MODE_DOWN);
    queue_load_time(1, 0, 0);
    queue_ticks(1);
    queue_load_time(0, 0, 1);
    queue_ticks(2);
    queue_mode(MODE_DOWN);
    queue_ticks(1);
    queue_request(rand_item(3'd5));
    queue_request(rand_item(3'd7));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: write_alarm(6'd1, 6'd23, 6'd59, 6'd59);
        1: write_alarm(6'd1, 6'd0, 6'd0, 6'd0);
        2: write_alarm(6'($urandom) & 6'h3e, 6'($urandom_range(0, 23)),
                       6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
        3: write_alarm(6'd1, 6'd31, 6'd63, 6'd63);
        4: write_alarm(6'd1, 6'($urandom_range(0, 23)),
                       6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
        default: write_alarm(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
      endcase
      case (ph)
        0: begin send_max_gap = 17; recv_max_gap = 17; end
        1: begin send_max_gap = 0;  recv_max_gap = 0;  end
        2: begin send_max_gap = 0;  recv_max_gap = 17; end
        3: begin send_max_gap = 17; recv_max_gap = 0;  end
        4: begin send_max_gap = 3;  recv_max_gap = 3;  end
        default: begin send_max_gap = 17; recv_max_gap = 17; end
      endcase
      queued_items = 0;
      while (queued_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0, 1, 2: begin
            // carry from the last seconds of a day into the next month/year
            queue_load_date(($urandom_range(0, 3) == 0) ? 99 : $urandom_range(0, 99),
                            ($urandom_range(0, 2) == 0) ? 12 : $urandom_range(1, 12),
                            $urandom_range(27, 31));
            queue_load_time(23, 59, $urandom_range(50, 59));
            queue_mode(MODE_UP);
            queue_ticks($urandom_range(2, 14));
          end
          3: begin
            // approach the alarm time from a few seconds before
            k = $urandom_range(0, 5);
            queue_load_time(al_hr, al_min, (al_sec > k) ? al_sec - k : 0);
            queue_mode(MODE_UP);
            queue_ticks(k + $urandom_range(1, 3));
          end
          4: begin
            queue_mode(MODE_DOWN);
            case ($urandom_range(0, 2))
              0: queue_load_time(0, 0, $urandom_range(0, 5));
              1: queue_load_time(0, 1, $urandom_range(0, 3));
              default: queue_load_time(1, 0, $urandom_range(0, 2));
            endcase
            queue_ticks($urandom_range(1, 8));
          end
          5, 6: begin
            queue_load_date($urandom_range(0, 127), $urandom_range(0, 15),
                            $urandom_range(0, 31));
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
              queue_step(2'($urandom_range(0, 3)), 1'($urandom));
          end
          7: begin
            queue_mode(2'($urandom_range(0, 3)));
            queue_ticks($urandom_range(1, 4));
          end
          8: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) queue_request(rand_item(3'($urandom)));
          end
          default: begin
            queue_load_time($urandom_range(0, 31), $urandom_range(0, 63),
                            $urandom_range(0, 63));
            queue_ticks($urandom_range(1, 3));
          end
        endcase
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("run covered %0d requests and %0d results over %0d alarm settings",
             n_requests, n_results, NUM_PHASES + 1);
    $display("saw %0d alarm rings, %0d count-down expiries, %0d midnight rollovers",
             n_rings, n_expiries, n_midnights);
    if (failures == 0) begin
      $display("calendar_clock_counter_top regression: pass");
    end else begin
      $display("calendar_clock_counter_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ccc_pkg.sv
rtl/ccc_if.sv
rtl/ccc_in_stage.sv
rtl/ccc_core.sv
rtl/ccc_out_stage.sv
rtl/calendar_clock_counter_top.sv
sim/tb.sv
